// ===== rtl/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and byte constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8v_pkg;

  localparam int unsigned PHASE_W = 4;

  localparam logic [PHASE_W-1:0] PH_LEAD     = 4'd0;
  localparam logic [PHASE_W-1:0] PH_LASTCONT = 4'd1;
  localparam logic [PHASE_W-1:0] PH_SECOND   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SURRCONT = 4'd3;
  localparam logic [PHASE_W-1:0] PH_FOURCONT = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SURRED   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_SURRLOW  = 4'd6;

  localparam logic [7:0] ASCII_MAX   = 8'd127;
  localparam logic [7:0] CONT_MAX    = 8'd191;
  localparam logic [7:0] BAD_LEAD    = 8'd247;
  localparam logic [7:0] TWO_MAX     = 8'd223;
  localparam logic [7:0] SURR_LEAD   = 8'd237;
  localparam logic [7:0] SURR_HI_MIN = 8'd160;
  localparam logic [7:0] SURR_HI_MAX = 8'd175;
  localparam logic [7:0] SURR_LO_MIN = 8'd176;
  localparam logic [7:0] THREE_MAX   = 8'd239;
  localparam logic [7:0] FOUR_MAX    = 8'd244;
  localparam logic [7:0] F4_CONT_MAX = 8'd143;

  typedef struct packed {
    logic               error_seen;
    logic [PHASE_W-1:0] phase;
    logic [7:0]         lead_value;
  } state_t;

  localparam state_t STATE_RESET = '{error_seen: 1'b0, phase: PH_LEAD, lead_value: 8'd0};

endpackage

`default_nettype wire

// ===== rtl/utf8v_in_if.sv =====
// ----------------------------------------------------------------------------
// utf8v_in_if
// Byte request channel: one string byte with end and empty markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  logic       no_byte;

  modport source (output valid, output data_byte, output is_last, output no_byte,
                  input ready);
  modport sink (input valid, input data_byte, input is_last, input no_byte,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8v_out_if.sv =====
// ----------------------------------------------------------------------------
// utf8v_out_if
// Result request channel: pass flag for one finished string.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8v_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink (input valid, input valid_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8v_step.sv =====
// ----------------------------------------------------------------------------
// utf8v_step
// Next-state and end-of-string flag for one byte request.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_step (
  input  var utf8v_pkg::state_t cur,
  input  wire logic [7:0]       data_byte,
  input  wire logic             is_last,
  input  wire logic             no_byte,
  output utf8v_pkg::state_t     nxt,
  output logic                  res
);

  utf8v_pkg::state_t upd;
  logic              is_cont;

  assign is_cont = (data_byte > utf8v_pkg::ASCII_MAX) && (data_byte <= utf8v_pkg::CONT_MAX);

  always_comb begin
    upd = cur;
    if (!no_byte && !cur.error_seen) begin
      case (cur.phase)
        utf8v_pkg::PH_LEAD: begin
          if (data_byte <= utf8v_pkg::ASCII_MAX) begin
            upd.phase = utf8v_pkg::PH_LEAD;
          end else if (data_byte >= utf8v_pkg::BAD_LEAD) begin
            upd.error_seen = 1'b1;
          end else if (data_byte <= utf8v_pkg::TWO_MAX) begin
            upd.phase = utf8v_pkg::PH_LASTCONT;
          end else begin
            upd.lead_value = data_byte;
            upd.phase      = utf8v_pkg::PH_SECOND;
          end
        end
        utf8v_pkg::PH_LASTCONT: begin
          if (is_cont) upd.phase = utf8v_pkg::PH_LEAD;
          else upd.error_seen = 1'b1;
        end
        utf8v_pkg::PH_SECOND: begin
          if (!is_cont) begin
            upd.error_seen = 1'b1;
          end else if (cur.lead_value == utf8v_pkg::SURR_LEAD &&
                       data_byte >= utf8v_pkg::SURR_HI_MIN) begin
            if (data_byte <= utf8v_pkg::SURR_HI_MAX) upd.phase = utf8v_pkg::PH_SURRCONT;
            else upd.error_seen = 1'b1;
          end else if (cur.lead_value > utf8v_pkg::THREE_MAX) begin
            if (cur.lead_value > utf8v_pkg::FOUR_MAX ||
                (cur.lead_value == utf8v_pkg::FOUR_MAX &&
                 data_byte > utf8v_pkg::F4_CONT_MAX)) begin
              upd.error_seen = 1'b1;
            end else begin
              upd.phase = utf8v_pkg::PH_FOURCONT;
            end
          end else begin
            upd.phase = utf8v_pkg::PH_LASTCONT;
          end
        end
        utf8v_pkg::PH_SURRCONT: begin
          if (is_cont) upd.phase = utf8v_pkg::PH_SURRED;
          else upd.error_seen = 1'b1;
        end
        utf8v_pkg::PH_FOURCONT: begin
          if (is_cont) upd.phase = utf8v_pkg::PH_LASTCONT;
          else upd.error_seen = 1'b1;
        end
        utf8v_pkg::PH_SURRED: begin
          if (data_byte == utf8v_pkg::SURR_LEAD) upd.phase = utf8v_pkg::PH_SURRLOW;
          else upd.error_seen = 1'b1;
        end
        utf8v_pkg::PH_SURRLOW: begin
          if (data_byte >= utf8v_pkg::SURR_LO_MIN && data_byte <= utf8v_pkg::CONT_MAX) begin
            upd.phase = utf8v_pkg::PH_LASTCONT;
          end else begin
            upd.error_seen = 1'b1;
          end
        end
        default: begin
          upd.error_seen = 1'b1;
        end
      endcase
    end
  end

  assign res = !upd.error_seen && (upd.phase == utf8v_pkg::PH_LEAD);
  assign nxt = is_last ? utf8v_pkg::STATE_RESET : upd;

endmodule

`default_nettype wire

// ===== rtl/utf8v_res_reg.sv =====
// ----------------------------------------------------------------------------
// utf8v_res_reg
// Output register for the per-string pass flag.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_res_reg (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire logic    res_bit,
  output logic         free,
  utf8v_out_if.source  result
);

  logic valid;
  logic valid_res;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      valid_res <= res_bit;
    end
  end

  assign result.valid     = valid;
  assign result.valid_res = valid_res;

endmodule

`default_nettype wire

// ===== rtl/utf8_stream_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Streaming UTF-8 checker with one pass flag per string.
// ----------------------------------------------------------------------------
// Takes one byte request per clock, while no stalled result holds the byte
// channel, and returns one result per string, on the request marked is_last.
// Every byte goes through an input register, then the range compares and
// phase update, then the result register; with no stall the sustained rate
// is one request per cycle. A stalled result holds the byte
// channel only once the next is_last request reaches the input register; plain
// bytes ahead of that request keep flowing. An empty string is one request
// with no_byte and is_last both set.
`default_nettype none

module utf8_stream_validator (
  input  wire logic   clk,
  input  wire logic   rst,
  utf8v_in_if.sink    stream,
  utf8v_out_if.source result
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic              s1_none;
  logic              s1_consume;
  logic              out_free;
  logic              step_res;
  utf8v_pkg::state_t state;
  utf8v_pkg::state_t state_next;

  assign s1_consume   = s1_valid && (!s1_last || out_free);
  assign stream.ready = !s1_valid || s1_consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      s1_byte <= stream.data_byte;
      s1_last <= stream.is_last;
      s1_none <= stream.no_byte;
    end
  end

  utf8v_step u_step (
    .cur       (state),
    .data_byte (s1_byte),
    .is_last   (s1_last),
    .no_byte   (s1_none),
    .nxt       (state_next),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= utf8v_pkg::STATE_RESET;
    end else if (s1_consume) begin
      state <= state_next;
    end
  end

  utf8v_res_reg u_res_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (s1_consume && s1_last),
    .res_bit (step_res),
    .free    (out_free),
    .result  (result)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> stream.ready)
    else $error("input stage empty but not ready");

  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    s1_consume && s1_last |=> state.phase == utf8v_pkg::PH_LEAD && !state.error_seen)
    else $error("state not cleared after end of string");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s1_valid && s1_last))
    else $error("result raised without an end-of-string request");

  a_error_latched: assert property (@(posedge clk) disable iff (rst)
    state.error_seen && !(s1_consume && s1_last) |=> state.error_seen)
    else $error("error flag dropped inside a string");

endmodule

`default_nettype wire

// ===== tb/utf8v_checker.sv =====
// ----------------------------------------------------------------------------
// utf8v_checker
// Watches both channels of the UTF-8 stream validator, predicts the pass flag
// of every string from the accepted byte requests and compares each result.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_checker (
  input  wire logic clk,
  input  wire logic rst,
  utf8v_in_if       stream,
  utf8v_out_if      result,
  output int        error_count,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  utf8v_pkg::state_t scan;
  logic              expected_flags[$];
  int                fails = 0;

  function automatic utf8v_pkg::state_t decode_byte(utf8v_pkg::state_t st,
                                                    logic [7:0] b);
    utf8v_pkg::state_t nx;
    logic              cont;
    nx = st;
    cont = (b > utf8v_pkg::ASCII_MAX) && (b <= utf8v_pkg::CONT_MAX);
    case (st.phase)
      utf8v_pkg::PH_LEAD: begin
        if (b > utf8v_pkg::ASCII_MAX) begin
          if (b >= utf8v_pkg::BAD_LEAD) begin
            nx.error_seen = 1'b1;
          end else if (b <= utf8v_pkg::TWO_MAX) begin
            nx.phase = utf8v_pkg::PH_LASTCONT;
          end else begin
            nx.lead_value = b;
            nx.phase = utf8v_pkg::PH_SECOND;
          end
        end
      end
      utf8v_pkg::PH_LASTCONT: begin
        if (cont) nx.phase = utf8v_pkg::PH_LEAD;
        else nx.error_seen = 1'b1;
      end
      utf8v_pkg::PH_SECOND: begin
        if (!cont) begin
          nx.error_seen = 1'b1;
        end else if (st.lead_value == utf8v_pkg::SURR_LEAD &&
                     b >= utf8v_pkg::SURR_HI_MIN) begin
          if (b <= utf8v_pkg::SURR_HI_MAX) nx.phase = utf8v_pkg::PH_SURRCONT;
          else nx.error_seen = 1'b1;
        end else if (st.lead_value > utf8v_pkg::THREE_MAX) begin
          if (st.lead_value > utf8v_pkg::FOUR_MAX ||
              (st.lead_value == utf8v_pkg::FOUR_MAX && b > utf8v_pkg::F4_CONT_MAX))
            nx.error_seen = 1'b1;
          else
            nx.phase = utf8v_pkg::PH_FOURCONT;
        end else begin
          nx.phase = utf8v_pkg::PH_LASTCONT;
        end
      end
      utf8v_pkg::PH_SURRCONT: begin
        if (cont) nx.phase = utf8v_pkg::PH_SURRED;
        else nx.error_seen = 1'b1;
      end
      utf8v_pkg::PH_FOURCONT: begin
        if (cont) nx.phase = utf8v_pkg::PH_LASTCONT;
        else nx.error_seen = 1'b1;
      end
      utf8v_pkg::PH_SURRED: begin
        if (b == utf8v_pkg::SURR_LEAD) nx.phase = utf8v_pkg::PH_SURRLOW;
        else nx.error_seen = 1'b1;
      end
      utf8v_pkg::PH_SURRLOW: begin
        if (b >= utf8v_pkg::SURR_LO_MIN && b <= utf8v_pkg::CONT_MAX)
          nx.phase = utf8v_pkg::PH_LASTCONT;
        else
          nx.error_seen = 1'b1;
      end
      default: begin
        nx.error_seen = 1'b1;
      end
    endcase
    return nx;
  endfunction

  always @(posedge clk) begin : track
    logic want;
    if (rst) begin
      scan = utf8v_pkg::STATE_RESET;
      expected_flags.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_flags.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual valid_res=%0b",
                   $time, result.valid_res);
        end else begin
          want = expected_flags.pop_front();
          if (result.valid_res !== want) begin
            fails++;
            $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                     $time, want, result.valid_res);
          end
        end
      end
      if (stream.valid && stream.ready) begin
        if (!stream.no_byte && !scan.error_seen)
          scan = decode_byte(scan, stream.data_byte);
        if (stream.is_last) begin
          expected_flags.push_back(!scan.error_seen && scan.phase == utf8v_pkg::PH_LEAD);
          scan = utf8v_pkg::STATE_RESET;
        end
      end
    end
    error_count <= fails;
    outstanding <= expected_flags.size();
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives byte strings into the UTF-8 stream validator: a directed set of
// edge cases, then random strings built mostly from well-formed sequences
// with some broken and noise bytes, under random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] bytes_t[$];

  logic clk;
  logic rst;
  logic steady;
  int   items_sent;
  int   error_count;
  int   outstanding;

  utf8v_in_if  stream_if ();
  utf8v_out_if result_if ();

  utf8_stream_validator u_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  utf8v_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .stream      (stream_if),
    .result      (result_if),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(128, 191));
  endfunction

  function automatic bytes_t make_string();
    bytes_t s;
    bytes_t c;
    int     n;
    int     kind;
    n = $urandom_range(1, 6);
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        c = {8'($urandom_range(0, 127))};
      end else if (kind < 40) begin
        c = {8'($urandom_range(128, 223)), cont_byte()};
      end else if (kind < 55) begin
        c = {8'($urandom_range(224, 239)), cont_byte(), cont_byte()};
      end else if (kind < 65) begin
        c = {utf8v_pkg::SURR_LEAD, cont_byte(), cont_byte()};
      end else if (kind < 75) begin
        c = {utf8v_pkg::SURR_LEAD, 8'($urandom_range(160, 175)), cont_byte(),
             utf8v_pkg::SURR_LEAD, 8'($urandom_range(176, 191)), cont_byte()};
      end else if (kind < 90) begin
        c = {8'($urandom_range(240, 246)), cont_byte(), cont_byte(), cont_byte()};
      end else begin
        c = {8'($urandom_range(0, 255))};
      end
      // break a sequence: cut it short or corrupt one trailing byte
      if (c.size() > 1 && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) c.pop_back();
        else c[$urandom_range(1, c.size() - 1)] = 8'($urandom_range(0, 255));
      end
      s = {s, c};
    end
    return s;
  endfunction

  task automatic send_request(input logic [7:0] b, input logic last, input logic none);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      stream_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_if.valid     <= 1'b1;
    stream_if.data_byte <= b;
    stream_if.is_last   <= last;
    stream_if.no_byte   <= none;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_string(input bytes_t s);
    foreach (s[i]) send_request(s[i], i == s.size() - 1, 1'b0);
  endtask

  task automatic send_random_string();
    bytes_t s;
    logic   empty_tail;
    steady = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 29) == 0) begin
      send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      return;
    end
    s = make_string();
    empty_tail = ($urandom_range(0, 6) == 0);
    foreach (s[i]) begin
      if ($urandom_range(0, 19) == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      send_request(s[i], !empty_tail && i == s.size() - 1, 1'b0);
    end
    if (empty_tail) send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  initial begin : result_side
    int run;
    int idle;
    int loops;
    result_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    loops = 0;
    forever begin
      loops++;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      result_if.ready <= 1'b1;
      repeat (run) @(posedge clk);
      // hold off for a random gap, and once long enough to back up the byte channel
      idle = (loops == 30) ? 400 : pick_gap();
      if (idle > 0) begin
        result_if.ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    bytes_t s;
    rst                 = 1'b1;
    steady              = 1'b0;
    items_sent          = 0;
    stream_if.valid     = 1'b0;
    stream_if.data_byte = 8'h00;
    stream_if.is_last   = 1'b0;
    stream_if.no_byte   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_request(8'h00, 1'b1, 1'b1);
    s = {8'h00, 8'h7F};
    send_string(s);
    s = {8'h80, 8'hBF};
    send_string(s);
    s = {8'hEF, 8'hBF, 8'hBF};
    send_string(s);
    s = {8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0, 8'h80};
    send_string(s);
    s = {8'hED, 8'hB0};
    send_string(s);
    s = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string(s);
    s = {8'hF4, 8'h90};
    send_string(s);
    s = {8'hF5, 8'h80};
    send_string(s);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h41, 1'b0, 1'b1);
    send_request(8'h41, 1'b1, 1'b0);
    send_request(8'hE2, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b1);

    while (items_sent < 1050) send_random_string();
    stream_if.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
